>>> hdl/smm_pkg.sv
// Shared constants and codes for the sparse matrix multiply unit.
package smm_pkg;

  localparam int ROWS_A_DEF    = 32;
  localparam int INNER_DIM_DEF = 32;
  localparam int COLS_B_DEF    = 32;
  localparam int DATA_W_DEF    = 16;

  localparam int MAX_RESULTS   = 32;

  localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE = 2'd2;
  localparam logic [1:0] FUNC_CLEAR   = 2'd3;

endpackage

>>> hdl/smm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module smm_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/sparse_csr_csc_matmul_unit.sv
// Sparse-by-sparse matrix multiply with dense stores and one shared MAC.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+---------------------------------
//  command   | start, busy (accept when  | func, row, col, value
//            | start & !busy)            |
//  result    | strobe (one cycle each)   | out_row, out_col, out_value, last
//
//  Load and out-of-range compute transactions leave busy low.
//  A compute transaction issues min(COLS_B,32) * INNER_DIM reads of the two
//  store RAMs, one per cycle into the shared multiplier and accumulator, and
//  then drains that pipeline before busy falls.
//  Reset and a clear transaction sweep the stores one address a cycle over
//  max(ROWS_A*INNER_DIM, INNER_DIM*COLS_B) addresses (1024 by default); busy
//  is high meanwhile. Results cannot be stalled.
module sparse_csr_csc_matmul_unit
  import smm_pkg::*;
#(
  parameter int ROWS_A    = ROWS_A_DEF,
  parameter int INNER_DIM = INNER_DIM_DEF,
  parameter int COLS_B    = COLS_B_DEF,
  parameter int DATA_W    = DATA_W_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic [4:0]         row,
  input  logic [4:0]         col,
  input  logic signed [15:0] value,
  output logic               strobe,
  output logic [4:0]         out_row,
  output logic [4:0]         out_col,
  output logic signed [15:0] out_value,
  output logic               last
);

  localparam int A_DEPTH   = ROWS_A * INNER_DIM;
  localparam int B_DEPTH   = INNER_DIM * COLS_B;
  localparam int A_AW      = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int B_AW      = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int CLR_DEPTH = (A_DEPTH > B_DEPTH) ? A_DEPTH : B_DEPTH;
  localparam int CLR_W     = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
  localparam int NRES      = (COLS_B < MAX_RESULTS) ? COLS_B : MAX_RESULTS;
  localparam int JW        = (NRES > 1) ? $clog2(NRES) : 1;
  localparam int KW        = (INNER_DIM > 1) ? $clog2(INNER_DIM) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_ISSUE = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]        state;
  logic [CLR_W-1:0]  clr_addr;
  logic [KW-1:0]     k;
  logic [JW-1:0]     j;
  logic [A_AW-1:0]   a_base;
  logic [A_AW-1:0]   a_ptr;
  logic [B_AW-1:0]   b_ptr;
  logic [4:0]        crow;

  logic              p1_valid;
  logic              p1_first;
  logic              p1_last;
  logic              p1_lastj;
  logic [JW-1:0]     p1_j;
  logic              p2_valid;
  logic              p2_first;
  logic              p2_last;
  logic              p2_lastj;
  logic [JW-1:0]     p2_j;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] acc_next;

  logic              accept;
  logic              load_a_ok;
  logic              load_b_ok;
  logic              compute_ok;
  logic              clearing;
  logic              k_end;
  logic              j_end;

  logic              a_we;
  logic              b_we;
  logic [A_AW-1:0]   a_waddr;
  logic [B_AW-1:0]   b_waddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] a_rdata;
  logic [DATA_W-1:0] b_rdata;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign clearing   = (state == ST_CLEAR);
  assign load_a_ok  = accept && (func == FUNC_LOAD_A) &&
                      (int'(row) < ROWS_A) && (int'(col) < INNER_DIM);
  assign load_b_ok  = accept && (func == FUNC_LOAD_B) &&
                      (int'(row) < INNER_DIM) && (int'(col) < COLS_B);
  assign compute_ok = accept && (func == FUNC_COMPUTE) && (int'(row) < ROWS_A);
  assign k_end      = (int'(k) == INNER_DIM - 1);
  assign j_end      = (int'(j) == NRES - 1);

  assign a_we    = (clearing && (int'(clr_addr) < A_DEPTH)) || load_a_ok;
  assign b_we    = (clearing && (int'(clr_addr) < B_DEPTH)) || load_b_ok;
  assign a_waddr = clearing ? A_AW'(clr_addr) : A_AW'(int'(row) * INNER_DIM + int'(col));
  assign b_waddr = clearing ? B_AW'(clr_addr) : B_AW'(int'(row) * COLS_B + int'(col));
  assign wdata   = clearing ? '0 : DATA_W'(value);

  smm_ram #(.WIDTH(DATA_W), .DEPTH(A_DEPTH), .ADDR_W(A_AW)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (wdata),
    .raddr (a_ptr),
    .rdata (a_rdata)
  );

  smm_ram #(.WIDTH(DATA_W), .DEPTH(B_DEPTH), .ADDR_W(B_AW)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (wdata),
    .raddr (b_ptr),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (func == FUNC_CLEAR)) begin
            state    <= ST_CLEAR;
            clr_addr <= '0;
          end else if (compute_ok) begin
            state <= ST_ISSUE;
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + CLR_W'(1);
          if (int'(clr_addr) == CLR_DEPTH - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_ISSUE: begin
          if (k_end && j_end) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!p1_valid && !p2_valid) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (compute_ok) begin
      crow   <= row;
      a_base <= A_AW'(int'(row) * INNER_DIM);
      a_ptr  <= A_AW'(int'(row) * INNER_DIM);
      b_ptr  <= '0;
      k      <= '0;
      j      <= '0;
    end else if (state == ST_ISSUE) begin
      if (k_end) begin
        k     <= '0;
        j     <= j + JW'(1);
        a_ptr <= a_base;
        b_ptr <= B_AW'(j) + B_AW'(1);
      end else begin
        k     <= k + KW'(1);
        a_ptr <= a_ptr + A_AW'(1);
        b_ptr <= b_ptr + B_AW'(COLS_B);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      p1_valid <= (state == ST_ISSUE);
      p2_valid <= p1_valid;
      strobe   <= p2_valid && p2_last;
    end
  end

  always_ff @(posedge clk) begin
    p1_first <= (k == '0);
    p1_last  <= k_end;
    p1_lastj <= j_end;
    p1_j     <= j;
    p2_first <= p1_first;
    p2_last  <= p1_last;
    p2_lastj <= p1_lastj;
    p2_j     <= p1_j;
    prod     <= DATA_W'(a_rdata * b_rdata);
  end

  always_comb begin
    acc_next = (p2_first ? '0 : acc) + prod;
  end

  always_ff @(posedge clk) begin
    if (p2_valid) begin
      acc <= acc_next;
      if (p2_last) begin
        out_row   <= crow;
        out_col   <= 5'(p2_j);
        out_value <= 16'($signed(acc_next));
        last      <= p2_lastj;
      end
    end
  end

endmodule

>>> hdl/smm_checker.sv
// Port-level assertions for the sparse matrix multiply unit, with its bind.
module smm_checker
  import smm_pkg::*;
#(
  parameter int ROWS_A    = ROWS_A_DEF,
  parameter int INNER_DIM = INNER_DIM_DEF,
  parameter int COLS_B    = COLS_B_DEF,
  parameter int DATA_W    = DATA_W_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [1:0]         func,
  input logic [4:0]         row,
  input logic [4:0]         col,
  input logic signed [15:0] value,
  input logic               strobe,
  input logic [4:0]         out_row,
  input logic [4:0]         out_col,
  input logic signed [15:0] out_value,
  input logic               last
);

  logic accept;
  logic unused_ok;

  assign accept    = start && !busy;
  assign unused_ok = ^{col, value, out_row, out_col, out_value, COLS_B, DATA_W,
                       INNER_DIM};

  a_reset_clears: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    accept && (func == FUNC_LOAD_A || func == FUNC_LOAD_B) |=> !busy)
    else $error("load transaction held the unit busy");

  a_bad_row_idle: assert property (@(posedge clk) disable iff (rst)
    accept && (func == FUNC_COMPUTE) && (int'(row) >= ROWS_A) |=> !busy && !strobe)
    else $error("out-of-range compute row did work");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (func == FUNC_COMPUTE) && (int'(row) < ROWS_A) |=> busy)
    else $error("compute transaction not started");

  a_more_results: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("unit idle before the final result of a row");

endmodule

bind sparse_csr_csc_matmul_unit smm_checker #(
  .ROWS_A    (ROWS_A),
  .INNER_DIM (INNER_DIM),
  .COLS_B    (COLS_B),
  .DATA_W    (DATA_W)
) u_smm_checker (.*);
